/* rtl/core/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier: time width,
// register indexes, gesture codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  // Width of the millisecond timestamps; all time differences wrap at this width.
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HOLD       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SOS        = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SOS_REPEAT = IDX_W'(3);

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(50);
  localparam logic [CFG_W-1:0] HOLD_RST       = CFG_W'(1500);
  localparam logic [CFG_W-1:0] SOS_RST        = CFG_W'(5000);
  localparam logic [CFG_W-1:0] SOS_REPEAT_RST = CFG_W'(2000);

  // Gesture codes.
  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_CLICK = 2'd1,
    GEST_HOLD  = 2'd2,
    GEST_SOS   = 2'd3
  } gesture_t;

  // Timing configuration seen by the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] sos_ms;
    logic [CFG_W-1:0] sos_repeat_ms;
  } cfg_t;

  // One poll word.
  typedef struct packed {
    logic              key_released;
    logic [TIME_W-1:0] now_ms;
    logic              authorized;
    logic              powered_up;
  } poll_t;

  // One result word.
  typedef struct packed {
    gesture_t gesture;
    logic     wake_screen;
    logic     start_clock;
    logic     restart_request;
    logic     shutdown_arm;
    logic     pressed_stable;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/bcc_cfg.sv */
// ----------------------------------------------------------------------------
// bcc_cfg
// Configuration register file. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg
  import bcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register writes, one register per write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.hold_ms       <= HOLD_RST;
      cfg_r.sos_ms        <= SOS_RST;
      cfg_r.sos_repeat_ms <= SOS_REPEAT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:   cfg_r.debounce_ms   <= wr_data;
        REG_HOLD:       cfg_r.hold_ms       <= wr_data;
        REG_SOS:        cfg_r.sos_ms        <= wr_data;
        REG_SOS_REPEAT: cfg_r.sos_repeat_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/bcc_in_stage.sv */
// ----------------------------------------------------------------------------
// bcc_in_stage
// Input register. Holds one poll word until the classifier takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_in_stage
  import bcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire poll_t in_word,
  output logic       word_vld,
  output poll_t      word,
  input  wire logic  take
);

  logic  vld_r;
  logic  vld_nxt;
  poll_t word_r;
  logic  load;

  // Stall only while a held word cannot move on this cycle.
  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

  assign word_vld = vld_r;
  assign word     = word_r;

endmodule

`default_nettype wire

/* rtl/core/bcc_step.sv */
// ----------------------------------------------------------------------------
// bcc_step
// Key state, debounce and gesture classification for one poll word, and the
// result register that feeds the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_step
  import bcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  word_vld,
  input  wire poll_t word,
  output logic       take,
  output logic       out_vld,
  input  wire logic  out_stall,
  output result_t    res
);

  // Key state.
  logic              raw_r, raw_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] press_r, press_nxt;
  logic [TIME_W-1:0] rel_r, rel_nxt;
  logic              half_r, half_nxt;

  // Result register.
  logic    out_vld_r, out_vld_nxt;
  result_t res_r, res_nxt;

  // Working values.
  logic              pressed;
  logic              changed;
  logic [TIME_W-1:0] press_t;
  logic [TIME_W-1:0] rel_t;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_rel;
  logic [TIME_W-1:0] press_len;
  logic [TIME_W-1:0] deb_t;
  logic [TIME_W-1:0] hold_t;
  logic [TIME_W-1:0] sos_t;
  logic [TIME_W-1:0] rep_t;

  // A word moves on when the result register is empty or being drained.
  assign take = word_vld && (!out_vld_r || !out_stall);

  assign deb_t  = TIME_W'(cfg.debounce_ms);
  assign hold_t = TIME_W'(cfg.hold_ms);
  assign sos_t  = TIME_W'(cfg.sos_ms);
  assign rep_t  = TIME_W'(cfg.sos_repeat_ms);

  // Record a raw level change with its timestamp.
  assign pressed = !word.key_released;
  assign changed = pressed != raw_r;
  assign press_t = (changed && pressed) ? word.now_ms : press_r;
  assign rel_t   = (changed && !pressed) ? word.now_ms : rel_r;

  // Wrapping time differences.
  assign held      = word.now_ms - press_t;
  assign since_rel = word.now_ms - rel_t;
  assign press_len = rel_t - press_t;

  // Debounce and classify.
  always_comb begin
    raw_nxt    = pressed;
    stable_nxt = stable_r;
    press_nxt  = press_t;
    rel_nxt    = rel_t;
    half_nxt   = half_r;

    res_nxt                 = '0;
    res_nxt.gesture         = GEST_NONE;
    res_nxt.wake_screen     = changed && pressed && word.authorized;
    res_nxt.start_clock     = changed && pressed && !word.authorized;

    if (pressed && stable_r) begin
      // Stable press: repeated SOS while authorized.
      if (word.authorized && (held >= sos_t)) begin
        press_nxt       = press_t + rep_t;
        res_nxt.gesture = GEST_SOS;
      end
    end else if (pressed) begin
      // Press not yet stable: debounce, then hold or a pending click.
      if (held >= deb_t) begin
        if (held >= hold_t) begin
          stable_nxt              = 1'b1;
          half_nxt                = 1'b0;
          res_nxt.gesture         = GEST_HOLD;
          res_nxt.shutdown_arm    = word.powered_up;
          res_nxt.restart_request = !word.powered_up;
        end else begin
          half_nxt = 1'b1;
        end
      end
    end else begin
      // Released: a debounced release completes a click or clears state.
      if (since_rel >= deb_t) begin
        if (half_r && (press_len < hold_t)) begin
          half_nxt        = 1'b0;
          res_nxt.gesture = GEST_CLICK;
        end else begin
          stable_nxt = 1'b0;
          half_nxt   = 1'b0;
        end
      end
    end

    res_nxt.pressed_stable = stable_nxt;
  end

  // Output valid follows takes and drains.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control and key state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
      press_r   <= '0;
      rel_r     <= '0;
      half_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        raw_r    <= raw_nxt;
        stable_r <= stable_nxt;
        press_r  <= press_nxt;
        rel_r    <= rel_nxt;
        half_r   <= half_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign res     = res_r;

  // A pending click is only ever tracked while the key is not stably pressed.
  a_half_not_stable: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> !stable_r)
    else $error("pending click while key is stably pressed");

  // A hold declaration leaves the key stably pressed.
  a_hold_sets_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_nxt.gesture == GEST_HOLD) |=> stable_r)
    else $error("hold declared but stable state not pressed");

  // A hold raises exactly one of restart and shutdown, and only a hold does.
  a_hold_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (res_nxt.restart_request || res_nxt.shutdown_arm)) |->
      (res_nxt.gesture == GEST_HOLD &&
       (res_nxt.restart_request != res_nxt.shutdown_arm)))
    else $error("restart or shutdown without a single hold action");

  // A held result stays put while the output is stalled.
  a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> (out_vld_r && $stable(res_r)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

/* rtl/core/button_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounced single-key gesture detector: click, press-and-hold, SOS.
// ----------------------------------------------------------------------------
// Each accepted poll word yields exactly one result word. The block accepts
// one poll per clock while the result side does not stall. A poll word is
// held first in the input register, then its result passes through the
// classifier into the result register. A single classifier pass lies between
// those registers, and its key state is updated once per poll. Timing registers are written
// through the cfg_ port, which is always ready; write only while idle.
`default_nettype none

module button_click_classifier
  import bcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration write port.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // Poll channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_key_released,
  input  wire logic [TIME_W-1:0] in_now_ms,
  input  wire logic              in_authorized,
  input  wire logic              in_powered_up,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_gesture,
  output logic                   out_wake_screen,
  output logic                   out_start_clock,
  output logic                   out_restart_request,
  output logic                   out_shutdown_arm,
  output logic                   out_pressed_stable
);

  cfg_t    cfg;
  poll_t   in_word;
  poll_t   word;
  logic    word_vld;
  logic    take;
  result_t res;

  assign cfg_ready = 1'b1;

  bcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Gather the poll fields into one word.
  always_comb begin
    in_word.key_released = in_key_released;
    in_word.now_ms       = in_now_ms;
    in_word.authorized   = in_authorized;
    in_word.powered_up   = in_powered_up;
  end

  bcc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .word_vld (word_vld),
    .word     (word),
    .take     (take)
  );

  bcc_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .word_vld  (word_vld),
    .word      (word),
    .take      (take),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Spread the result word onto the output ports.
  assign out_gesture         = res.gesture;
  assign out_wake_screen     = res.wake_screen;
  assign out_start_clock     = res.start_clock;
  assign out_restart_request = res.restart_request;
  assign out_shutdown_arm    = res.shutdown_arm;
  assign out_pressed_stable  = res.pressed_stable;

endmodule

`default_nettype wire

/* dv/bcc_checker.sv */
// ----------------------------------------------------------------------------
// bcc_checker
// Watches the poll, result and register channels of the button click
// classifier. It keeps its own copy of the key state and timing registers,
// predicts one result word per accepted poll word and compares every
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bcc_checker
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_key_released,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              in_authorized,
  input  logic              in_powered_up,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_gesture,
  input  logic              out_wake_screen,
  input  logic              out_start_clock,
  input  logic              out_restart_request,
  input  logic              out_shutdown_arm,
  input  logic              out_pressed_stable,
  output int                fail_count,
  output int                words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow timing registers and key state.
  cfg_t              timing;
  logic              key_down;
  logic              key_stable;
  logic              click_pending;
  logic [TIME_W-1:0] t_press;
  logic [TIME_W-1:0] t_release;

  // Predicted result words, oldest first.
  result_t gesture_q[$];

  // Advance the key state by one poll and return the result word it causes.
  function automatic result_t classify_poll(input logic released, input logic [TIME_W-1:0] now,
                                            input logic auth, input logic pwr);
    result_t           r;
    logic              pressed;
    logic [TIME_W-1:0] span;
    r = '0;
    pressed = !released;

    // A raw level change is recorded first, with its timestamp.
    if (pressed != key_down) begin
      key_down = pressed;
      if (pressed) begin
        t_press = now;
        if (auth) r.wake_screen = 1'b1;
        else r.start_clock = 1'b1;
      end else begin
        t_release = now;
      end
    end

    if (key_stable && key_down) begin
      // Key held and debounced: only SOS can fire, and only while authorized.
      span = now - t_press;
      if (auth && span >= TIME_W'(timing.sos_ms)) begin
        t_press = t_press + TIME_W'(timing.sos_repeat_ms);
        r.gesture = GEST_SOS;
      end
    end else if (key_down) begin
      // Press not yet debounced: either a pending click or a hold.
      span = now - t_press;
      if (span >= TIME_W'(timing.debounce_ms)) begin
        if (span >= TIME_W'(timing.hold_ms)) begin
          key_stable = 1'b1;
          click_pending = 1'b0;
          r.gesture = GEST_HOLD;
          if (pwr) r.shutdown_arm = 1'b1;
          else r.restart_request = 1'b1;
        end else begin
          click_pending = 1'b1;
        end
      end
    end else begin
      // Released: a debounced release closes a click or ends a hold silently.
      span = now - t_release;
      if (span >= TIME_W'(timing.debounce_ms)) begin
        span = t_release - t_press;
        if (click_pending && span < TIME_W'(timing.hold_ms)) begin
          click_pending = 1'b0;
          r.gesture = GEST_CLICK;
        end else begin
          key_stable = 1'b0;
          click_pending = 1'b0;
        end
      end
    end

    r.pressed_stable = key_stable;
    return r;
  endfunction

  // Count and report one field that differs from its prediction.
  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // All three channels are sampled at the rising edge, before any update.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      timing = {DEBOUNCE_RST, HOLD_RST, SOS_RST, SOS_REPEAT_RST};
      key_down = 1'b0;
      key_stable = 1'b0;
      click_pending = 1'b0;
      t_press = '0;
      t_release = '0;
      gesture_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:   timing.debounce_ms = cfg_data;
          REG_HOLD:       timing.hold_ms = cfg_data;
          REG_SOS:        timing.sos_ms = cfg_data;
          REG_SOS_REPEAT: timing.sos_repeat_ms = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (gesture_q.size() == 0) begin
          $display("%0t ns: result word expected none, got gesture %0d", $time, out_gesture);
          fail_count++;
        end else begin
          want = gesture_q.pop_front();
          check_field("gesture", int'(want.gesture), int'(out_gesture));
          check_field("wake_screen", int'(want.wake_screen), int'(out_wake_screen));
          check_field("start_clock", int'(want.start_clock), int'(out_start_clock));
          check_field("restart_request", int'(want.restart_request), int'(out_restart_request));
          check_field("shutdown_arm", int'(want.shutdown_arm), int'(out_shutdown_arm));
          check_field("pressed_stable", int'(want.pressed_stable), int'(out_pressed_stable));
        end
      end

      if (in_valid && !in_stall)
        gesture_q.push_back(classify_poll(in_key_released, in_now_ms,
                                          in_authorized, in_powered_up));
    end
    words_pending <= gesture_q.size();
  end

endmodule

/* dv/button_click_classifier_tb.sv */
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// Drives poll words into the button click classifier: a short directed run
// of clicks, holds and SOS across a time wrap, then random key gestures and
// noise under several timing settings, with bursty input and a stalling
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module button_click_classifier_tb;
  import bcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_key_released = 1'b1;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              in_authorized = 1'b0;
  logic              in_powered_up = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_gesture;
  logic              out_wake_screen;
  logic              out_start_clock;
  logic              out_restart_request;
  logic              out_shutdown_arm;
  logic              out_pressed_stable;
  int                fail_count;
  int                words_pending;

  // Receiver pacing.
  stall_mode_t stall_mode = STALL_NONE;
  logic        long_hold_req = 1'b0;
  bit          long_hold_served = 1'b0;
  int          hold_cycles = 0;
  int unsigned stall_phase = 0;

  // Sender state: running time, timing shadow used to shape gestures, bursts.
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned       cfg_debounce_ms = 32'(DEBOUNCE_RST);
  int unsigned       cfg_hold_ms = 32'(HOLD_RST);
  int unsigned       cfg_sos_ms = 32'(SOS_RST);
  int unsigned       cfg_sos_repeat_ms = 32'(SOS_REPEAT_RST);
  int unsigned       step_max = 4;
  int unsigned       words_sent = 0;
  bit                gaps_on = 1'b1;
  int                burst_left = 0;

  button_click_classifier uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key_released     (in_key_released),
    .in_now_ms           (in_now_ms),
    .in_authorized       (in_authorized),
    .in_powered_up       (in_powered_up),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gesture         (out_gesture),
    .out_wake_screen     (out_wake_screen),
    .out_start_clock     (out_start_clock),
    .out_restart_request (out_restart_request),
    .out_shutdown_arm    (out_shutdown_arm),
    .out_pressed_stable  (out_pressed_stable)
  );

  bcc_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key_released     (in_key_released),
    .in_now_ms           (in_now_ms),
    .in_authorized       (in_authorized),
    .in_powered_up       (in_powered_up),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gesture         (out_gesture),
    .out_wake_screen     (out_wake_screen),
    .out_start_clock     (out_start_clock),
    .out_restart_request (out_restart_request),
    .out_shutdown_arm    (out_shutdown_arm),
    .out_pressed_stable  (out_pressed_stable),
    .fail_count          (fail_count),
    .words_pending       (words_pending)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: one long hold-off on request, otherwise the current pattern.
  always @(posedge clk) begin
    stall_phase++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (long_hold_req && !long_hold_served) begin
      long_hold_served = 1'b1;
      hold_cycles = 300;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  // Offer one poll word, wait for it to be taken, then maybe leave a gap.
  task automatic send_poll(input logic released, input logic [TIME_W-1:0] now,
                           input logic auth, input logic pwr);
    in_valid <= 1'b1;
    in_key_released <= released;
    in_now_ms <= now;
    in_authorized <= auth;
    in_powered_up <= pwr;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load a timing setting while idle, plus one write to an unused index.
  task automatic configure(input int unsigned deb, input int unsigned hold,
                           input int unsigned sos, input int unsigned rep);
    logic [IDX_W-1:0] spare_idx;
    drain();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_HOLD, hold);
    write_reg(REG_SOS, sos);
    write_reg(REG_SOS_REPEAT, rep);
    spare_idx = IDX_W'($urandom_range(int'(REG_SOS_REPEAT) + 1, (1 << IDX_W) - 1));
    write_reg(spare_idx, $urandom_range(0, 65535));
    cfg_debounce_ms = deb;
    cfg_hold_ms = hold;
    cfg_sos_ms = sos;
    cfg_sos_repeat_ms = rep;
    step_max = deb;
    if (hold > step_max) step_max = hold;
    if (sos > step_max) step_max = sos;
    if (rep > step_max) step_max = rep;
    step_max = step_max / 8 + 4;
  endtask

  // One well-formed gesture: optional bounce, a press of chosen length, release.
  task automatic play_gesture();
    logic [TIME_W-1:0] t_edge;
    int unsigned       dur;
    int unsigned       n;
    bit                auth;
    bit                pwr;
    auth = ($urandom_range(0, 3) != 0);
    pwr = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: dur = $urandom_range(0, cfg_hold_ms);
      1: dur = $urandom_range(cfg_hold_ms, cfg_sos_ms);
      default: dur = cfg_sos_ms + $urandom_range(0, 3 * cfg_sos_repeat_ms + step_max);
    endcase

    // Contact bounce before the press settles.
    repeat ($urandom_range(0, 2)) begin
      send_poll(1'b0, clock_ms, auth, pwr);
      clock_ms += $urandom_range(0, cfg_debounce_ms);
      send_poll(1'b1, clock_ms, auth, pwr);
      clock_ms += $urandom_range(0, cfg_debounce_ms);
    end

    t_edge = clock_ms;
    n = 0;
    while (n < 2 || (clock_ms - t_edge) < TIME_W'(dur)) begin
      if ($urandom_range(0, 15) == 0) auth = !auth;
      send_poll(1'b0, clock_ms, auth, pwr);
      clock_ms += $urandom_range(0, step_max);
      n++;
    end

    t_edge = clock_ms;
    n = 0;
    while (n < 2 || (clock_ms - t_edge) <= TIME_W'(cfg_debounce_ms)) begin
      send_poll(1'b1, clock_ms, auth, pwr);
      clock_ms += $urandom_range(0, step_max);
      n++;
    end
  endtask

  // A few polls with random level, flags and sometimes a jump in time.
  task automatic play_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
      else clock_ms += $urandom_range(0, step_max);
      send_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int unsigned n_words, input stall_mode_t mode, input bit gaps);
    int unsigned target;
    stall_mode <= mode;
    gaps_on = gaps;
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) == 0) play_noise();
      else play_gesture();
    end
  endtask

  // Main stimulus.
  initial begin
    logic [TIME_W-1:0] base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    step_max = int'(SOS_RST) / 8 + 4;
    stall_mode <= STALL_LIGHT;

    // Directed: field extremes, then click, unauthorized hold and SOS with repeat.
    base = 32'hFFFF_FF00;
    send_poll(1'b1, '0, 1'b0, 1'b0);
    send_poll(1'b1, '1, 1'b1, 1'b1);
    // Click just below the time wrap, on the exact debounce thresholds.
    send_poll(1'b0, base, 1'b1, 1'b0);
    send_poll(1'b0, base + 49, 1'b1, 1'b0);
    send_poll(1'b0, base + 50, 1'b1, 1'b0);
    send_poll(1'b1, base + 120, 1'b1, 1'b0);
    send_poll(1'b1, base + 169, 1'b1, 1'b0);
    send_poll(1'b1, base + 170, 1'b1, 1'b0);
    // Hold while unauthorized: restart, no SOS, then a silent release.
    send_poll(1'b0, base + 1000, 1'b0, 1'b0);
    send_poll(1'b0, base + 1050, 1'b0, 1'b0);
    send_poll(1'b0, base + 2500, 1'b0, 1'b0);
    send_poll(1'b0, base + 9000, 1'b0, 1'b0);
    send_poll(1'b1, base + 9100, 1'b0, 1'b0);
    send_poll(1'b1, base + 9150, 1'b0, 1'b0);
    // Hold while powered up, then SOS and one repeat on their thresholds.
    send_poll(1'b0, base + 10000, 1'b1, 1'b1);
    send_poll(1'b0, base + 11500, 1'b1, 1'b1);
    send_poll(1'b0, base + 15000, 1'b1, 1'b1);
    send_poll(1'b0, base + 16999, 1'b1, 1'b1);
    send_poll(1'b0, base + 17000, 1'b1, 1'b1);
    send_poll(1'b1, base + 17100, 1'b1, 1'b1);
    send_poll(1'b1, base + 17150, 1'b1, 1'b1);
    clock_ms = base + 20000;

    // Random gestures under the reset timing.
    run_phase(200, STALL_LIGHT, 1'b1);

    // Short timings; the receiver holds off long while words keep coming.
    configure(3, 12, 20, 5);
    long_hold_req <= 1'b1;
    run_phase(120, STALL_NONE, 1'b0);
    run_phase(130, STALL_HEAVY, 1'b1);

    // All timings at zero.
    configure(0, 0, 0, 0);
    run_phase(150, STALL_PERIODIC, 1'b1);

    // All timings at their maximum, no idling on either side.
    configure(65535, 65535, 65535, 65535);
    run_phase(150, STALL_NONE, 1'b0);

    // Debounce above hold, SOS below hold, no repeat advance.
    configure(40, 10, 5, 0);
    run_phase(150, STALL_LIGHT, 1'b1);

    // Random settings, one small and one over the full range.
    configure($urandom_range(0, 300), $urandom_range(0, 300),
              $urandom_range(0, 300), $urandom_range(0, 300));
    run_phase(125, STALL_HEAVY, 1'b1);
    configure($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(125, STALL_LIGHT, 1'b1);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
